### src/rme_pkg.sv
`default_nettype none

package rme_pkg;

   localparam int PIX_PER_GROUP = 8;
   localparam int OUT_COLOR_W   = 16;
   localparam int DIM_W         = 12;
   localparam int DONE_W        = 25;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;

   // escape code that opens a value byte / repeat count pair
   localparam logic [7:0] ESC_BYTE = 8'h76;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG_COLOR  = 2'd0,
      CSR_BG_COLOR  = 2'd1,
      CSR_WIDTH_PX  = 2'd2,
      CSR_HEIGHT_PX = 2'd3
   } csr_idx_type;

   typedef logic [OUT_COLOR_W-1:0] color_type;
   typedef logic [DIM_W-1:0]       dim_type;

   // one decoded group, as handed from the parser to the result stage
   typedef struct packed {
      logic       emit;
      logic [7:0] value;
      logic [7:0] repeat_count;
      logic       last_group;
   } group_type;

endpackage

`default_nettype wire

### src/rme_req_if.sv
`default_nettype none

interface rme_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

`default_nettype wire

### src/rme_rsp_if.sv
`default_nettype none

interface rme_rsp_if;
   logic               valid;
   logic               ready;
   rme_pkg::color_type pix0;
   rme_pkg::color_type pix1;
   rme_pkg::color_type pix2;
   rme_pkg::color_type pix3;
   rme_pkg::color_type pix4;
   rme_pkg::color_type pix5;
   rme_pkg::color_type pix6;
   rme_pkg::color_type pix7;
   logic [7:0]         repeat_count;
   logic               last_group;

   modport source (
      output valid, output pix0, output pix1, output pix2, output pix3,
      output pix4, output pix5, output pix6, output pix7,
      output repeat_count, output last_group, input ready
   );
   modport sink (
      input valid, input pix0, input pix1, input pix2, input pix3,
      input pix4, input pix5, input pix6, input pix7,
      input repeat_count, input last_group, output ready
   );
endinterface

`default_nettype wire

### src/rle_mono_bitmap_expander.sv
// Path: an accepted word waits in the input register, then is parsed and color
//   mapped into the result register, which drives rsp_if.
// Throughput: one word per cycle; req_if.ready stays high while the result register
//   is empty or being taken, so a stalled result holds back at most one word.
// Reset: synchronous, active high; clears the parser, pixel count and both valid
//   flags, and sets fg_color to all ones, bg_color, width_px and height_px to zero.
`default_nettype none

module rle_mono_bitmap_expander #(
   parameter int COLOR_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rme_req_if.sink                                req_if,
   rme_rsp_if.source                              rsp_if,
   input  wire logic                              csr_we,
   input  wire logic [rme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rme_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rme_pkg::*;

   // stored color width: COLOR_WIDTH, capped at the output field width
   localparam int CW = (COLOR_WIDTH < OUT_COLOR_W) ? COLOR_WIDTH : OUT_COLOR_W;

   // configuration registers
   logic [CW-1:0] fg_ff;
   logic [CW-1:0] bg_ff;
   dim_type       width_ff;
   dim_type       height_ff;

   // input register
   logic          in_vld_ff, in_vld_in;
   logic          in_type_ff;
   logic [7:0]    in_byte_ff;

   // result register
   logic                                  out_vld_ff, out_vld_in;
   color_type [PIX_PER_GROUP-1:0]         pix_ff, pix_in;
   logic [7:0]                            rep_ff;
   logic                                  last_ff;

   logic                                  accept;
   logic                                  out_free;
   logic                                  advance;
   group_type                             grp;
   logic [PIX_PER_GROUP-1:0][CW-1:0]      map_pix;

   // advance the input word whenever the result register has room for it
   assign out_free      = !out_vld_ff || rsp_if.ready;
   assign advance       = in_vld_ff && out_free;
   assign req_if.ready  = !in_vld_ff || advance;
   assign accept        = req_if.valid && req_if.ready;

   // config writes; host must write only while the datapath is empty, not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff     <= {CW{1'b1}};
         bg_ff     <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_FG_COLOR:  fg_ff     <= csr_wdata[CW-1:0];
            CSR_BG_COLOR:  bg_ff     <= csr_wdata[CW-1:0];
            CSR_WIDTH_PX:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT_PX: height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // input register: load on accept, drop once the word moves on
   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff <= req_if.req_type;
         in_byte_ff <= req_if.data_byte;
      end
   end

   // escape parser and pixel counter; state moves only when the word advances
   rme_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .go        (advance),
      .req_type  (in_type_ff),
      .data_byte (in_byte_ff),
      .width_px  (width_ff),
      .height_px (height_ff),
      .grp       (grp)
   );

   // bit-to-color map of the group value
   rme_colmap #(
      .CW (CW)
   ) u_colmap (
      .value    (grp.value),
      .fg_color (fg_ff),
      .bg_color (bg_ff),
      .pix      (map_pix)
   );

   always_comb begin
      for (int i = 0; i < PIX_PER_GROUP; i++) begin
         pix_in[i] = color_type'(map_pix[i]);
      end
   end

   // result register: load when a group is emitted, clear when taken
   always_comb begin
      out_vld_in = out_vld_ff;
      if (advance && grp.emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && grp.emit) begin
         pix_ff  <= pix_in;
         rep_ff  <= grp.repeat_count;
         last_ff <= grp.last_group;
      end
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.pix0         = pix_ff[0];
   assign rsp_if.pix1         = pix_ff[1];
   assign rsp_if.pix2         = pix_ff[2];
   assign rsp_if.pix3         = pix_ff[3];
   assign rsp_if.pix4         = pix_ff[4];
   assign rsp_if.pix5         = pix_ff[5];
   assign rsp_if.pix6         = pix_ff[6];
   assign rsp_if.pix7         = pix_ff[7];
   assign rsp_if.repeat_count = rep_ff;
   assign rsp_if.last_group   = last_ff;

endmodule

`default_nettype wire

### src/rme_parse.sv
`default_nettype none

module rme_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic               req_type,
   input  wire logic [7:0]         data_byte,
   input  wire rme_pkg::dim_type   width_px,
   input  wire rme_pkg::dim_type   height_px,
   output rme_pkg::group_type      grp
);
   import rme_pkg::*;

   typedef enum logic [1:0] {
      P_BYTE  = 2'd0,
      P_VALUE = 2'd1,
      P_COUNT = 2'd2
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [7:0]          held_ff, held_in;
   logic [DONE_W-1:0]   done_ff, done_in;
   logic                fin_ff, fin_in;

   logic [2*DIM_W-1:0]  total;
   logic                reached;
   logic                grp_go;
   logic [7:0]          grp_value;
   logic [7:0]          grp_rep;
   logic [DONE_W-1:0]   next_done;
   logic                next_last;

   assign total     = width_px * height_px;
   assign reached   = done_ff >= DONE_W'(total);
   assign next_done = done_ff + DONE_W'({grp_rep, 3'b000});
   assign next_last = next_done >= DONE_W'(total);

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      grp_go    = 1'b0;
      grp_value = data_byte;
      grp_rep   = 8'd1;
      if (req_type) begin
         phase_in = P_BYTE;
         held_in  = '0;
      end else begin
         case (phase_ff)
            P_VALUE: begin
               held_in  = data_byte;
               phase_in = P_COUNT;
            end
            P_COUNT: begin
               phase_in  = P_BYTE;
               grp_value = held_ff;
               grp_rep   = data_byte;
               grp_go    = 1'b1;
            end
            default: begin
               phase_in = P_BYTE;
               if (!(fin_ff || reached)) begin
                  if (data_byte == ESC_BYTE) begin
                     phase_in = P_VALUE;
                  end else begin
                     grp_go = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   // a zero repeat count drops the group
   always_comb begin
      grp.emit         = grp_go && (grp_rep != 8'd0);
      grp.value        = grp_value;
      grp.repeat_count = grp_rep;
      grp.last_group   = next_last;
      done_in          = done_ff;
      fin_in           = fin_ff;
      if (req_type) begin
         done_in = '0;
         fin_in  = 1'b0;
      end else if (grp.emit) begin
         done_in = next_done;
         if (next_last) begin
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_BYTE;
         held_ff  <= '0;
         done_ff  <= '0;
         fin_ff   <= 1'b0;
      end else if (go) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         done_ff  <= done_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

`default_nettype wire

### src/rme_colmap.sv
`default_nettype none

module rme_colmap #(
   parameter int CW = 16
) (
   input  wire logic [7:0]                                   value,
   input  wire logic [CW-1:0]                                fg_color,
   input  wire logic [CW-1:0]                                bg_color,
   output logic [rme_pkg::PIX_PER_GROUP-1:0][CW-1:0]         pix
);
   import rme_pkg::*;

   // pixel 0 takes the top bit
   always_comb begin
      for (int i = 0; i < PIX_PER_GROUP; i++) begin
         pix[i] = value[PIX_PER_GROUP-1-i] ? fg_color : bg_color;
      end
   end

endmodule

`default_nettype wire

### src/rme_checker.sv
`default_nettype none

module rme_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_repeat_count,
   input wire logic       rsp_last_group
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_ready && !reset) |-> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_ready && !reset) |->
         ($stable(rsp_repeat_count) && $stable(rsp_last_group)))
      else $error("rsp payload changed while stalled");

   // a zero repeat never reaches the output
   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count != 8'd0))
      else $error("result word with zero repeat count");

   // a free output side never backs up the input
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req not ready although rsp side is ready");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind rle_mono_bitmap_expander rme_checker u_rme_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_repeat_count (rsp_if.repeat_count),
   .rsp_last_group   (rsp_if.last_group)
);

`default_nettype wire

### sim/tb_rle_mono_bitmap_expander.sv
`default_nettype none

module tb_rle_mono_bitmap_expander;
   import rme_pkg::*;

   // request kinds carried in req_type
   localparam bit REQ_BYTE  = 1'b0;
   localparam bit REQ_START = 1'b1;

   // words pass the input register, then the result register; settle before touching CSRs
   localparam int SETTLE_CYCLES   = 6;
   localparam int RANDOM_PHASES   = 10;
   localparam int WORDS_PER_PHASE = 160;

   typedef enum bit [1:0] {
      WANT_GROUP,
      WANT_VALUE,
      WANT_COUNT
   } parse_state_type;

   typedef struct packed {
      color_type [PIX_PER_GROUP-1:0] pix;
      logic [7:0]                    times;
      logic                          last;
   } group_word_type;

   // Tracks the decoder state on every accepted request word and keeps the groups
   // the block still owes, oldest first.
   class expander_scoreboard_type;
      color_type            fg;
      color_type            bg;
      dim_type              width;
      dim_type              height;
      parse_state_type      state;
      logic [7:0]           held;
      logic [DONE_W-1:0]    done_px;
      bit                   finished_flag;
      group_word_type       groups_due[$];
      int                   mismatches;
      int                   checked;
      int                   bitmaps_done;

      function new();
         fg           = '1;
         bg           = '0;
         width        = '0;
         height       = '0;
         mismatches   = 0;
         checked      = 0;
         bitmaps_done = 0;
         restart();
      endfunction

      function void restart();
         state         = WANT_GROUP;
         held          = '0;
         done_px       = '0;
         finished_flag = 1'b0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_FG_COLOR:  fg = v;
            CSR_BG_COLOR:  bg = v;
            CSR_WIDTH_PX:  width = v[DIM_W-1:0];
            CSR_HEIGHT_PX: height = v[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned total_px();
         int unsigned w;
         int unsigned h;
         w = width;
         h = height;
         return w * h;
      endfunction

      function bit drawn();
         return finished_flag || (done_px >= total_px());
      endfunction

      function void add_group(logic [7:0] value, logic [7:0] times);
         group_word_type g;
         int i;
         if (times == 0) return;
         for (i = 0; i < PIX_PER_GROUP; i++) g.pix[i] = value[7-i] ? fg : bg;
         done_px = done_px + (DONE_W'(times) << 3);
         g.times = times;
         g.last  = (done_px >= total_px());
         if (g.last) begin
            finished_flag = 1'b1;
            bitmaps_done++;
         end
         groups_due.push_back(g);
      endfunction

      // returns 1 when the word is decoded, 0 when the block drops it
      function bit predict_word(bit kind, logic [7:0] b);
         if (kind == REQ_START) begin
            restart();
            return 1'b1;
         end
         case (state)
            WANT_VALUE: begin
               held  = b;
               state = WANT_COUNT;
               return 1'b1;
            end
            WANT_COUNT: begin
               state = WANT_GROUP;
               add_group(held, b);
               return 1'b1;
            end
            default: begin
               state = WANT_GROUP;
               if (drawn()) return 1'b0;
               if (b == ESC_BYTE) state = WANT_VALUE;
               else add_group(b, 8'd1);
               return 1'b1;
            end
         endcase
      endfunction

      function void check_group(group_word_type got);
         group_word_type want;
         int i;
         if (groups_due.size() == 0) begin
            $display("%0t: group with none pending, expected nothing, got %h", $time, got);
            mismatches++;
            return;
         end
         want = groups_due.pop_front();
         checked++;
         for (i = 0; i < PIX_PER_GROUP; i++) begin
            if (got.pix[i] !== want.pix[i]) begin
               $display("%0t: pix%0d expected %h got %h", $time, i, want.pix[i], got.pix[i]);
               mismatches++;
            end
         end
         if (got.times !== want.times) begin
            $display("%0t: repeat_count expected %0d got %0d", $time, want.times, got.times);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_group expected %b got %b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rme_req_if req_bus ();
   rme_rsp_if rsp_bus ();

   rle_mono_bitmap_expander uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   expander_scoreboard_type sb;

   // idle switches per phase; both off gives back-to-back stretches
   bit send_idle;
   bit recv_idle;

   int words_sent;
   int words_decoded;
   int phase_decoded;
   int settings;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned idle_len(bit enabled);
      int unsigned r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic color_type pick_color();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 30) return '1;
      return color_type'($urandom);
   endfunction

   // Result side: drop ready for random stretches, change it only on the falling edge.
   initial begin
      int unsigned stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = idle_len(recv_idle);
         end
      end
   end

   // Sample result words at the rising edge and hand them to the scoreboard.
   always @(posedge clock) begin
      group_word_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.pix[0] = rsp_bus.pix0;
         seen.pix[1] = rsp_bus.pix1;
         seen.pix[2] = rsp_bus.pix2;
         seen.pix[3] = rsp_bus.pix3;
         seen.pix[4] = rsp_bus.pix4;
         seen.pix[5] = rsp_bus.pix5;
         seen.pix[6] = rsp_bus.pix6;
         seen.pix[7] = rsp_bus.pix7;
         seen.times  = rsp_bus.repeat_count;
         seen.last   = rsp_bus.last_group;
         sb.check_group(seen);
      end
   end

   // Present one request word, optionally after a gap, and hold it until accepted.
   task automatic send_word(bit kind, logic [7:0] b);
      int unsigned gap;
      gap = idle_len(send_idle);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.data_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      words_sent++;
      if (sb.predict_word(kind, b)) begin
         words_decoded++;
         phase_decoded++;
      end
   endtask

   task automatic send_byte(logic [7:0] b);
      send_word(REQ_BYTE, b);
   endtask

   task automatic send_start();
      send_word(REQ_START, 8'($urandom));
   endtask

   // Drop valid, wait for every owed group, then let the pipeline settle.
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.groups_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   // Dimensions go out with random upper bits, which the block must drop.
   task automatic set_dims(int unsigned w, int unsigned h);
      write_reg(CSR_WIDTH_PX, {4'($urandom), 12'(w)});
      write_reg(CSR_HEIGHT_PX, {4'($urandom), 12'(h)});
   endtask

   task automatic send_escape(logic [7:0] value, logic [7:0] times);
      send_byte(ESC_BYTE);
      send_byte(value);
      send_byte(times);
   endtask

   // One group of a well-formed stream, with a little noise and some broken escapes.
   task automatic feed_group();
      int unsigned r;
      int unsigned rc;
      logic [7:0]  b;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_start();
      end else if (r < 7) begin
         // abort an escape halfway
         send_byte(ESC_BYTE);
         if ($urandom_range(0, 1)) send_byte(8'($urandom));
         send_start();
      end else if (r < 45) begin
         rc = $urandom_range(0, 99);
         if (rc < 10) b = 8'd0;
         else if (rc < 20) b = 8'hff;
         else if (rc < 30) b = 8'($urandom_range(13, 254));
         else b = 8'($urandom_range(1, 12));
         send_escape(($urandom_range(0, 9) == 0) ? ESC_BYTE : 8'($urandom), b);
      end else begin
         do b = 8'($urandom); while (b == ESC_BYTE);
         send_byte(b);
      end
   endtask

   // Start a bitmap, stream groups until done or at the target, then trail a few bytes.
   task automatic feed_bitmap(int target);
      send_start();
      while (!sb.drawn() && phase_decoded < target) feed_group();
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
   endtask

   task automatic configure_phase(int p);
      settings++;
      case (p)
         0: begin
            // color extremes swapped, largest bitmap that never completes here
            write_reg(CSR_FG_COLOR, '0);
            write_reg(CSR_BG_COLOR, '1);
            set_dims(4095, 4095);
         end
         1: set_dims(4095, 1);
         2: set_dims(0, $urandom_range(1, 4095));
         default: begin
            if ($urandom_range(0, 99) < 70) write_reg(CSR_FG_COLOR, pick_color());
            if ($urandom_range(0, 99) < 70) write_reg(CSR_BG_COLOR, pick_color());
            if ($urandom_range(0, 99) < 85) begin
               set_dims(($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 48),
                        $urandom_range(1, 10));
            end
         end
      endcase
   endtask

   initial begin
      int p;
      int target;
      sb                = new();
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = REQ_BYTE;
      req_bus.data_byte = '0;
      send_idle         = 1'b1;
      recv_idle         = 1'b1;
      words_sent        = 0;
      words_decoded     = 0;
      settings          = 1;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset dimensions are zero: an empty bitmap drops every byte, escapes included.
      send_byte(8'hff);
      send_byte(ESC_BYTE);
      drain();

      // 16x2 bitmap: four plain groups' worth of pixels.
      settings++;
      write_reg(CSR_FG_COLOR, '1);
      write_reg(CSR_BG_COLOR, '0);
      set_dims(16, 2);
      send_start();
      send_byte(8'h00);
      send_byte(8'hff);
      send_escape(ESC_BYTE, 8'd0);   // zero repeat: nothing out
      send_escape(ESC_BYTE, 8'd1);   // escape code as a group
      send_byte(8'ha5);              // completes the bitmap
      send_byte(8'h3c);              // dropped after completion
      send_start();
      send_escape(8'h80, 8'hff);     // overshoot past the total in one group
      send_byte(8'h55);              // dropped
      send_start();
      send_byte(ESC_BYTE);
      send_byte(8'h7f);
      send_start();                  // abort the escape before its count
      send_byte(8'hfe);
      drain();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         send_idle = (p % 4 == 0) || (p % 4 == 1);
         recv_idle = (p % 4 == 0) || (p % 4 == 2);
         configure_phase(p);
         target        = (p == 0) ? 40 : (p == 2) ? 20 : WORDS_PER_PHASE;
         phase_decoded = 0;
         // bytes before any start run under the old bitmap state with the new size
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
         while (phase_decoded < target) feed_bitmap(target);
         drain();
      end

      $display("Decoded %0d of %0d stream words under %0d register settings;", words_decoded,
               words_sent, settings);
      $display("checked %0d groups and saw %0d bitmaps complete, with overshoot and aborts.",
               sb.checked, sb.bitmaps_done);
      if (sb.mismatches == 0 && sb.groups_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
